FILE: rtl/afbt_pkg.sv
// afbt_pkg: request/response types and operation and branch codes
// for the alu with flags and branch test block; no dependencies
`timescale 1ns / 1ps

package afbt_pkg;

	localparam int unsigned DataW = 32;

	localparam logic [4:0] FN_ADD   = 5'd0;
	localparam logic [4:0] FN_MUL   = 5'd1;
	localparam logic [4:0] FN_ADDC  = 5'd2;
	localparam logic [4:0] FN_SUB   = 5'd3;
	localparam logic [4:0] FN_SUBC  = 5'd4;
	localparam logic [4:0] FN_LSL   = 5'd5;
	localparam logic [4:0] FN_LSR   = 5'd6;
	localparam logic [4:0] FN_AND   = 5'd7;
	localparam logic [4:0] FN_XOR   = 5'd8;
	localparam logic [4:0] FN_BIC   = 5'd9;
	localparam logic [4:0] FN_BST   = 5'd10;
	localparam logic [4:0] FN_OR    = 5'd11;
	localparam logic [4:0] FN_COPYB = 5'd12;
	localparam logic [4:0] FN_CMP   = 5'd13;
	localparam logic [4:0] FN_MOVHI = 5'd14;
	localparam logic [4:0] FN_ASR   = 5'd15;
	localparam logic [4:0] FN_COPYA = 5'd16;

	localparam logic [3:0] BC_NE     = 4'd1;
	localparam logic [3:0] BC_EQ     = 4'd2;
	localparam logic [3:0] BC_GT     = 4'd3;
	localparam logic [3:0] BC_LT     = 4'd4;
	localparam logic [3:0] BC_GTS    = 4'd5;
	localparam logic [3:0] BC_LTS    = 4'd6;
	localparam logic [3:0] BC_ALWAYS = 4'd7;
	localparam logic [3:0] BC_GTE    = 4'd8;
	localparam logic [3:0] BC_GTES   = 4'd9;
	localparam logic [3:0] BC_LTE    = 4'd10;
	localparam logic [3:0] BC_LTES   = 4'd11;

	localparam logic [DataW-1:0] MovhiMask = 32'h0000_ffff;

	typedef struct packed {
		logic [4:0]       func;
		logic [DataW-1:0] operand_a;
		logic [DataW-1:0] operand_b;
		logic             update_carry;
		logic             update_codes;
		logic [3:0]       branch_cond;
	} afbt_req_t;

	typedef struct packed {
		logic [DataW-1:0] result;
		logic             carry_now;
		logic             overflow_now;
		logic             negative_now;
		logic             zero_now;
		logic             cond_met;
	} afbt_rsp_t;

endpackage

FILE: rtl/alu_with_flags_and_branch_test.sv
// alu_with_flags_and_branch_test: 32-bit alu with kept c/v/n/z flags and branch test
// depends on afbt_pkg for request/response types and codes
`timescale 1ns / 1ps
//
// Usage:
//   Requests arrive on req (valid/ready); each carries an operation code, two
//   operands, flag update enables and a branch condition. Each request gives
//   exactly one response on rsp (valid/ready): the low 32 bits of the result,
//   the four flags after this request's update and the branch test outcome.
//   A request is taken into an input register; the alu, the 32x32 multiplier
//   and the flag update sit between that register and the response register.
//   Response valid rises as the request enters the response register; one
//   request is taken every cycle unless rsp stalls. Add with carry and subtract
//   with borrow see the carry left by the request just before, through the
//   registered flag loop. When the receiver stalls, the response register holds
//   and the input register fills, after which req_ready drops until rsp is taken.
//   Reset clears both valid bits and all four flags.

module alu_with_flags_and_branch_test
	import afbt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  afbt_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output afbt_rsp_t rsp
);

	logic      valid_s1;
	afbt_req_t req_s1;
	logic      valid_s2;
	afbt_rsp_t rsp_s2;
	logic      carry_q, overflow_q, negative_q, zero_q;
	logic      adv_s1;

	logic [4:0]       sh;
	logic [DataW-1:0] a, b, q;
	logic [DataW:0]   sum, dif, sumc, difc, lsl_v;
	logic [DataW:0]   prod;
	logic             nc, no, nn, nz;
	logic             c_new, v_new, n_new, z_new, sne, met;

	assign adv_s1    = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || adv_s1;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// operation
	always_comb begin
		a     = req_s1.operand_a;
		b     = req_s1.operand_b;
		sh    = b[4:0];
		sum   = {1'b0, a} + {1'b0, b};
		sumc  = sum + {{DataW{1'b0}}, carry_q};
		dif   = {1'b0, a} - {1'b0, b};
		difc  = dif - {{DataW{1'b0}}, carry_q};
		prod  = {1'b0, a} * {1'b0, b};
		lsl_v = {1'b0, a} << sh;
		q     = '0;
		nc    = 1'b0;
		no    = 1'b0;
		nn    = 1'b0;
		nz    = (a == b);
		case (req_s1.func)
			FN_ADD: begin
				q  = sum[DataW-1:0];
				nc = sum[DataW];
			end
			FN_MUL: begin
				q  = prod[DataW-1:0];
				nc = prod[DataW];
			end
			FN_ADDC: begin
				q  = sumc[DataW-1:0];
				nc = sumc[DataW];
			end
			FN_SUB: begin
				q  = dif[DataW-1:0];
				nc = dif[DataW];
			end
			FN_SUBC: begin
				q  = difc[DataW-1:0];
				nc = difc[DataW];
			end
			FN_LSL: begin
				q  = lsl_v[DataW-1:0];
				nc = lsl_v[DataW];
			end
			FN_LSR:   q = a >> sh;
			FN_AND:   q = a & b;
			FN_XOR:   q = a ^ b;
			FN_BIC:   q = a & ~({{(DataW-1){1'b0}}, 1'b1} << sh);
			FN_BST:   q = a | ({{(DataW-1){1'b0}}, 1'b1} << sh);
			FN_OR:    q = a | b;
			FN_COPYB: q = b;
			FN_CMP: begin
				q  = dif[DataW-1:0];
				nc = !dif[DataW];
				no = (a[DataW-1] != b[DataW-1]) && (dif[DataW-1] == b[DataW-1]);
				nn = dif[DataW-1];
			end
			FN_MOVHI: q = a | (b & MovhiMask);
			FN_ASR:   q = DataW'($signed(a) >>> sh);
			FN_COPYA: q = a;
			default:  q = '0;
		endcase
	end

	// flag update and branch test
	always_comb begin
		c_new = req_s1.update_carry ? nc : carry_q;
		v_new = req_s1.update_codes ? no : overflow_q;
		n_new = req_s1.update_codes ? nn : negative_q;
		z_new = req_s1.update_codes ? nz : zero_q;
		sne   = n_new ^ v_new;
		case (req_s1.branch_cond)
			BC_NE:     met = !z_new;
			BC_EQ:     met = z_new;
			BC_GT:     met = c_new && !z_new;
			BC_LT:     met = !c_new;
			BC_GTS:    met = !z_new && !sne;
			BC_LTS:    met = sne;
			BC_ALWAYS: met = 1'b1;
			BC_GTE:    met = c_new;
			BC_GTES:   met = !sne;
			BC_LTE:    met = !c_new || z_new;
			BC_LTES:   met = sne || z_new;
			default:   met = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			carry_q    <= 1'b0;
			overflow_q <= 1'b0;
			negative_q <= 1'b0;
			zero_q     <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && adv_s1) begin
				carry_q    <= c_new;
				overflow_q <= v_new;
				negative_q <= n_new;
				zero_q     <= z_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (valid_s1 && adv_s1) begin
			rsp_s2.result       <= q;
			rsp_s2.carry_now    <= c_new;
			rsp_s2.overflow_now <= v_new;
			rsp_s2.negative_now <= n_new;
			rsp_s2.zero_now     <= z_new;
			rsp_s2.cond_met     <= met;
		end
	end

endmodule
